FILE: src/rk3pp_pkg.sv
package rk3pp_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int FT_W      = 31;
    localparam int SC_W      = 16;
    localparam int DIV_W     = 36;
    localparam int SAT_W     = 66;

    // divide by three: split the halved numerator at D3_LO_W bits,
    // then a reciprocal multiply on the folded sum
    localparam int D3_LO_W   = 16;
    localparam int D3_HI_W   = DIV_W - 1 - D3_LO_W;
    localparam int D3_SUM_W  = D3_HI_W + 1;
    localparam int D3_PROD_W = 2 * D3_SUM_W;
    localparam int D3_SHIFT  = 21;
    localparam logic [D3_LO_W-1:0]  D3_SPLIT = D3_LO_W'((2 ** D3_LO_W) / 3);
    localparam logic [D3_SUM_W-1:0] D3_RECIP = D3_SUM_W'((2 ** D3_SHIFT + 2) / 3);

    localparam logic signed [DATA_W-1:0] Q_ONE = DATA_W'(1) << FRAC_BITS;
    localparam logic signed [DATA_W-1:0] Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [63:0] MUL_RND = 64'sd1 <<< (FRAC_BITS - 1);

    localparam logic [FT_W-1:0] FT_RESET = FT_W'(1) << FRAC_BITS;
    localparam logic [SC_W-1:0] SC_RESET = SC_W'(1024);

    localparam logic CFG_FINAL_TIME = 1'b0;
    localparam logic CFG_STEP_COUNT = 1'b1;

    localparam logic [1:0] PH_UPDATE = 2'd3;
    localparam logic [3:0] SUB_LAST  = 4'd10;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_DIV_H,
        OP_H_WB,
        OP_STAGE,
        OP_DIFF,
        OP_SMUL,
        OP_K_WB,
        OP_HMUL,
        OP_T_WB,
        OP_DIV6,
        OP_Y_WB,
        OP_OUT
    } t_op;

    typedef struct packed {
        t_op        op;
        logic       lane;
        logic [1:0] slot;
    } t_cmd;

    typedef struct packed {
        logic div_done;
    } t_stat;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
        if (v > SAT_W'(Q_MAX)) return Q_MAX;
        if (v < SAT_W'(Q_MIN)) return Q_MIN;
        return v[DATA_W-1:0];
    endfunction

    function automatic logic ovf32(input logic signed [SAT_W-1:0] v);
        return (v > SAT_W'(Q_MAX)) || (v < SAT_W'(Q_MIN));
    endfunction

    // one step: phases 0..2 evaluate a stage and its slope, phase 3 updates
    function automatic t_cmd prog(input logic [1:0] phase, input logic [3:0] sub);
        t_cmd c;
        c.op   = OP_NONE;
        c.lane = 1'b0;
        c.slot = phase;
        if (phase == PH_UPDATE) begin
            c.op   = OP_DIV6;
            c.lane = sub[0];
            c.slot = 2'd0;
        end else begin
            case (sub)
                4'd0:  c.op = OP_STAGE;
                4'd1:  c.op = OP_DIFF;
                4'd2:  c.op = OP_SMUL;
                4'd3:  c.op = OP_K_WB;
                4'd4:  begin c.op = OP_DIFF; c.lane = 1'b1; end
                4'd5:  begin c.op = OP_SMUL; c.lane = 1'b1; end
                4'd6:  begin c.op = OP_K_WB; c.lane = 1'b1; end
                4'd7:  c.op = OP_HMUL;
                4'd8:  c.op = OP_T_WB;
                4'd9:  begin c.op = OP_HMUL; c.lane = 1'b1; end
                4'd10: begin c.op = OP_T_WB; c.lane = 1'b1; end
                default: c.op = OP_NONE;
            endcase
        end
        return c;
    endfunction

endpackage

FILE: src/rk3pp_div.sv
module rk3pp_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [rk3pp_pkg::DIV_W-1:0]   i_dividend,
    input  logic [rk3pp_pkg::SC_W-1:0]    i_divisor,
    output logic [rk3pp_pkg::DIV_W-1:0]   o_quotient,
    output logic                          o_done
);

    logic                          r_busy;
    logic                          r_done;
    logic [5:0]                    r_cnt;
    logic [rk3pp_pkg::DIV_W-1:0]   r_num;
    logic [rk3pp_pkg::SC_W-1:0]    r_rem;
    logic [rk3pp_pkg::SC_W-1:0]    r_den;
    logic [rk3pp_pkg::SC_W:0]      w_sh;
    logic [rk3pp_pkg::SC_W:0]      w_sub;
    logic                          w_ge;

    always_comb begin
        w_sh  = {r_rem, r_num[rk3pp_pkg::DIV_W-1]};
        w_ge  = w_sh >= {1'b0, r_den};
        w_sub = w_sh - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_num  <= i_dividend;
            r_rem  <= '0;
            r_den  <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_sub[rk3pp_pkg::SC_W-1:0] : w_sh[rk3pp_pkg::SC_W-1:0];
            r_num <= {r_num[rk3pp_pkg::DIV_W-2:0], w_ge};
            r_cnt <= r_cnt + 6'd1;
            if (r_cnt == 6'(rk3pp_pkg::DIV_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    assign o_quotient = r_num;
    assign o_done     = r_done;

endmodule

FILE: src/rk3pp_ctrl.sv
module rk3pp_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    input  logic [rk3pp_pkg::SC_W-1:0]  i_step_count,
    input  rk3pp_pkg::t_stat            i_stat,
    output rk3pp_pkg::t_cmd             o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HDIV,
        ST_HWAIT,
        ST_RUN,
        ST_DWAIT,
        ST_OUT
    } t_state;

    t_state                       r_state, n_state;
    logic [1:0]                   r_phase, n_phase;
    logic [3:0]                   r_sub, n_sub;
    logic [rk3pp_pkg::SC_W-1:0]   r_steps, n_steps;
    logic                         r_out_valid, n_out_valid;
    rk3pp_pkg::t_cmd              w_prog;

    always_comb begin
        w_prog      = rk3pp_pkg::prog(r_phase, r_sub);
        n_state     = r_state;
        n_phase     = r_phase;
        n_sub       = r_sub;
        n_steps     = r_steps;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd.op    = rk3pp_pkg::OP_NONE;
        o_cmd.lane  = 1'b0;
        o_cmd.slot  = 2'd0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = rk3pp_pkg::OP_LOAD;
                    n_steps  = '0;
                    n_state  = (i_step_count == '0) ? ST_OUT : ST_HDIV;
                end
            end
            ST_HDIV: begin
                o_cmd.op = rk3pp_pkg::OP_DIV_H;
                n_state  = ST_HWAIT;
            end
            ST_HWAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.op = rk3pp_pkg::OP_H_WB;
                    n_phase  = 2'd0;
                    n_sub    = 4'd0;
                    n_state  = ST_RUN;
                end
            end
            ST_RUN: begin
                o_cmd = w_prog;
                if (w_prog.op == rk3pp_pkg::OP_DIV6) begin
                    n_state = ST_DWAIT;
                end else if (r_sub == rk3pp_pkg::SUB_LAST) begin
                    n_sub   = 4'd0;
                    n_phase = r_phase + 2'd1;
                end else begin
                    n_sub = r_sub + 4'd1;
                end
            end
            ST_DWAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.op   = rk3pp_pkg::OP_Y_WB;
                    o_cmd.lane = r_sub[0];
                    if (r_sub[0]) begin
                        n_steps = r_steps + rk3pp_pkg::SC_W'(1);
                        n_phase = 2'd0;
                        n_sub   = 4'd0;
                        n_state = (n_steps == i_step_count) ? ST_OUT : ST_RUN;
                    end else begin
                        n_sub   = 4'd1;
                        n_state = ST_RUN;
                    end
                end
            end
            ST_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.op    = rk3pp_pkg::OP_OUT;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_phase     <= '0;
            r_sub       <= '0;
            r_steps     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_sub       <= n_sub;
            r_steps     <= n_steps;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

FILE: src/rk3pp_dp.sv
module rk3pp_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  rk3pp_pkg::t_cmd                     i_cmd,
    output rk3pp_pkg::t_stat                    o_stat,
    input  logic signed [rk3pp_pkg::DATA_W-1:0] i_prey_start,
    input  logic signed [rk3pp_pkg::DATA_W-1:0] i_predator_start,
    input  logic [rk3pp_pkg::FT_W-1:0]          i_final_time,
    input  logic [rk3pp_pkg::SC_W-1:0]          i_step_count,
    output logic signed [rk3pp_pkg::DATA_W-1:0] o_prey_final,
    output logic signed [rk3pp_pkg::DATA_W-1:0] o_predator_final,
    output logic                                o_saturated
);

    localparam int W = rk3pp_pkg::DATA_W;
    localparam int S = rk3pp_pkg::SAT_W;

    logic signed [W-1:0]   r_ya, r_yb, r_sa, r_sb, r_d, r_h;
    logic signed [W-1:0]   r_k [0:2][0:1];
    logic signed [W-1:0]   r_t [0:2][0:1];
    logic signed [63:0]    r_prod;
    logic                  r_neg;
    logic                  r_clamp;
    logic signed [W-1:0]   r_prey_o, r_pred_o;
    logic                  r_sat_o;

    logic [rk3pp_pkg::DIV_W-1:0]     r_n6, r_q6;
    logic [rk3pp_pkg::DIV_W-2:0]     r_d3_hi;
    logic [rk3pp_pkg::D3_SUM_W-1:0]  r_d3_sum;
    logic [1:0]                      r_d6_pipe;
    logic                            r_d6_done;

    logic signed [W-1:0]   w_yl, w_kl, w_mq;
    logic signed [63:0]    w_rnd;
    logic signed [S-1:0]   w_diff, w_s2a, w_s2b, w_s3a, w_s3b, w_v, w_mag, w_yn, w_q;
    logic                  w_hit;
    logic                  w_div_start;
    logic [rk3pp_pkg::DIV_W-1:0] w_dividend, w_quot;
    logic                  w_div_done;
    logic [rk3pp_pkg::DIV_W-2:0]     w_half;
    logic [rk3pp_pkg::D3_PROD_W-1:0] w_recip;
    logic [rk3pp_pkg::DIV_W-1:0]     w_q6;

    always_comb begin
        w_yl   = i_cmd.lane ? r_yb : r_ya;
        w_kl   = r_k[i_cmd.slot][i_cmd.lane];
        w_rnd  = (r_prod + rk3pp_pkg::MUL_RND) >>> rk3pp_pkg::FRAC_BITS;
        w_mq   = rk3pp_pkg::sat32(S'(w_rnd));
        w_diff = i_cmd.lane ? (S'(r_sa) - S'(rk3pp_pkg::Q_ONE))
                            : (S'(rk3pp_pkg::Q_ONE) - S'(r_sb));
        w_s2a  = S'(r_ya) + S'(r_t[0][0]);
        w_s2b  = S'(r_yb) + S'(r_t[0][1]);
        w_s3a  = S'(r_ya) + ((S'(r_t[0][0]) + S'(r_t[1][0]) + S'(2)) >>> 2);
        w_s3b  = S'(r_yb) + ((S'(r_t[0][1]) + S'(r_t[1][1]) + S'(2)) >>> 2);
        w_v    = S'(r_t[0][i_cmd.lane]) + S'(r_t[1][i_cmd.lane])
               + (S'(r_t[2][i_cmd.lane]) <<< 2);
        w_mag  = w_v[S-1] ? -w_v : w_v;
        w_q    = S'({1'b0, r_q6});
        w_yn   = r_neg ? (S'(w_yl) - w_q) : (S'(w_yl) + w_q);

        // n/6 = (n/2)/3; n/2 = hi*2^16 + lo folds to hi*21845 + (hi + lo)/3
        w_half  = r_n6[rk3pp_pkg::DIV_W-1:1];
        w_recip = rk3pp_pkg::D3_PROD_W'(r_d3_sum) * rk3pp_pkg::D3_PROD_W'(rk3pp_pkg::D3_RECIP);
        w_q6    = rk3pp_pkg::DIV_W'(r_d3_hi)
                + rk3pp_pkg::DIV_W'(w_recip[rk3pp_pkg::D3_PROD_W-1:rk3pp_pkg::D3_SHIFT]);

        w_hit = 1'b0;
        case (i_cmd.op)
            rk3pp_pkg::OP_STAGE: begin
                if (i_cmd.slot == 2'd1)
                    w_hit = rk3pp_pkg::ovf32(w_s2a) | rk3pp_pkg::ovf32(w_s2b);
                else if (i_cmd.slot == 2'd2)
                    w_hit = rk3pp_pkg::ovf32(w_s3a) | rk3pp_pkg::ovf32(w_s3b);
            end
            rk3pp_pkg::OP_DIFF:  w_hit = rk3pp_pkg::ovf32(w_diff);
            rk3pp_pkg::OP_K_WB,
            rk3pp_pkg::OP_T_WB:  w_hit = rk3pp_pkg::ovf32(S'(w_rnd));
            rk3pp_pkg::OP_Y_WB:  w_hit = rk3pp_pkg::ovf32(w_yn);
            default:             w_hit = 1'b0;
        endcase

        w_div_start = (i_cmd.op == rk3pp_pkg::OP_DIV_H);
        w_dividend  = rk3pp_pkg::DIV_W'(i_final_time);
    end

    rk3pp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (i_step_count),
        .o_quotient (w_quot),
        .o_done     (w_div_done)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clamp <= 1'b0;
        end else if (i_cmd.op == rk3pp_pkg::OP_LOAD) begin
            r_clamp <= 1'b0;
        end else begin
            r_clamp <= r_clamp | w_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d6_pipe <= '0;
            r_d6_done <= 1'b0;
        end else begin
            r_d6_pipe <= {r_d6_pipe[0], i_cmd.op == rk3pp_pkg::OP_DIV6};
            r_d6_done <= r_d6_pipe[1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_d3_hi  <= (rk3pp_pkg::DIV_W-1)'(w_half[rk3pp_pkg::DIV_W-2:rk3pp_pkg::D3_LO_W])
                  * (rk3pp_pkg::DIV_W-1)'(rk3pp_pkg::D3_SPLIT);
        r_d3_sum <= rk3pp_pkg::D3_SUM_W'(w_half[rk3pp_pkg::DIV_W-2:rk3pp_pkg::D3_LO_W])
                  + rk3pp_pkg::D3_SUM_W'(w_half[rk3pp_pkg::D3_LO_W-1:0]);
        r_q6     <= w_q6;
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            rk3pp_pkg::OP_LOAD: begin
                r_ya <= i_prey_start;
                r_yb <= i_predator_start;
            end
            rk3pp_pkg::OP_H_WB: r_h <= W'(w_quot[rk3pp_pkg::FT_W-1:0]);
            rk3pp_pkg::OP_STAGE: begin
                if (i_cmd.slot == 2'd1) begin
                    r_sa <= rk3pp_pkg::sat32(w_s2a);
                    r_sb <= rk3pp_pkg::sat32(w_s2b);
                end else if (i_cmd.slot == 2'd2) begin
                    r_sa <= rk3pp_pkg::sat32(w_s3a);
                    r_sb <= rk3pp_pkg::sat32(w_s3b);
                end else begin
                    r_sa <= r_ya;
                    r_sb <= r_yb;
                end
            end
            rk3pp_pkg::OP_DIFF: r_d <= rk3pp_pkg::sat32(w_diff);
            rk3pp_pkg::OP_SMUL: r_prod <= 64'(r_d) * 64'(i_cmd.lane ? r_sb : r_sa);
            rk3pp_pkg::OP_K_WB: r_k[i_cmd.slot][i_cmd.lane] <= w_mq;
            rk3pp_pkg::OP_HMUL: r_prod <= 64'(r_h) * 64'(w_kl);
            rk3pp_pkg::OP_T_WB: r_t[i_cmd.slot][i_cmd.lane] <= w_mq;
            rk3pp_pkg::OP_DIV6: begin
                r_neg <= w_v[S-1];
                r_n6  <= w_mag[rk3pp_pkg::DIV_W-1:0] + rk3pp_pkg::DIV_W'(3);
            end
            rk3pp_pkg::OP_Y_WB: begin
                if (i_cmd.lane) r_yb <= rk3pp_pkg::sat32(w_yn);
                else            r_ya <= rk3pp_pkg::sat32(w_yn);
            end
            rk3pp_pkg::OP_OUT: begin
                r_prey_o <= r_ya;
                r_pred_o <= r_yb;
                r_sat_o  <= r_clamp;
            end
            default: ;
        endcase
    end

    assign o_stat.div_done  = w_div_done | r_d6_done;
    assign o_prey_final     = r_prey_o;
    assign o_predator_final = r_pred_o;
    assign o_saturated      = r_sat_o;

endmodule

FILE: src/rk3_predator_prey_integrator.sv
// Lotka-Volterra integrator, three-stage SSP Runge-Kutta, signed Q16.16.
// Input channel: i_in_valid/o_in_ready carry one request of prey_start and
// predator_start. Output channel: o_out_valid/i_out_ready return
// prey_final, predator_final and the sticky saturated flag.
// Config: i_cfg_we writes i_cfg_data to final_time (index 0) or
// step_count (index 1). The user must write only while no request is
// in flight; the block itself does not enforce it. Each request runs
// a serial step-size divide, then per step 33 ops on the shared 32x32
// multiplier and adders, plus two reciprocal divides by six.
// Zero step_count returns the start values.
// One request is worked at a time; the next is accepted while the
// previous result still waits in the output register.
// If the receiver stalls, the finished result of the following request
// waits in the core until the output register is free.
// Reset (synchronous, active low) clears the control state and loads
// final_time = 1.0 and step_count = 1024.
module rk3_predator_prey_integrator (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic signed [rk3pp_pkg::DATA_W-1:0] i_prey_start,
    input  logic signed [rk3pp_pkg::DATA_W-1:0] i_predator_start,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [rk3pp_pkg::DATA_W-1:0] o_prey_final,
    output logic signed [rk3pp_pkg::DATA_W-1:0] o_predator_final,
    output logic                                o_saturated,
    input  logic                                i_cfg_we,
    input  logic                                i_cfg_index,
    input  logic [rk3pp_pkg::FT_W-1:0]          i_cfg_data
);

    logic [rk3pp_pkg::FT_W-1:0] r_final_time;
    logic [rk3pp_pkg::SC_W-1:0] r_step_count;
    rk3pp_pkg::t_cmd            w_cmd;
    rk3pp_pkg::t_stat           w_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_final_time <= rk3pp_pkg::FT_RESET;
            r_step_count <= rk3pp_pkg::SC_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index == rk3pp_pkg::CFG_FINAL_TIME)
                r_final_time <= i_cfg_data;
            else if (i_cfg_index == rk3pp_pkg::CFG_STEP_COUNT)
                r_step_count <= i_cfg_data[rk3pp_pkg::SC_W-1:0];
        end
    end

    rk3pp_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_out_ready  (i_out_ready),
        .o_out_valid  (o_out_valid),
        .i_step_count (r_step_count),
        .i_stat       (w_stat),
        .o_cmd        (w_cmd)
    );

    rk3pp_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .i_prey_start     (i_prey_start),
        .i_predator_start (i_predator_start),
        .i_final_time     (r_final_time),
        .i_step_count     (r_step_count),
        .o_prey_final     (o_prey_final),
        .o_predator_final (o_predator_final),
        .o_saturated      (o_saturated)
    );

    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("ready stayed high after a request was taken");

    a_div_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.div_done |=> !w_stat.div_done)
        else $error("divider done held longer than one cycle");

    a_out_from_core: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !$past(o_out_valid && !i_out_ready))
            |-> $past(w_cmd.op == rk3pp_pkg::OP_OUT))
        else $error("output valid without a result load");

endmodule

FILE: sim/rk3_predator_prey_checker.sv
`default_nettype none

module rk3_predator_prey_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                i_in_ready,
    input  logic signed [rk3pp_pkg::DATA_W-1:0] i_prey_start,
    input  logic signed [rk3pp_pkg::DATA_W-1:0] i_predator_start,
    input  logic                                i_out_valid,
    input  logic                                i_out_ready,
    input  logic signed [rk3pp_pkg::DATA_W-1:0] i_prey_final,
    input  logic signed [rk3pp_pkg::DATA_W-1:0] i_predator_final,
    input  logic                                i_saturated,
    input  logic                                i_cfg_we,
    input  logic                                i_cfg_index,
    input  logic [rk3pp_pkg::FT_W-1:0]          i_cfg_data,
    output int                                  o_fail_count,
    output int                                  o_pending,
    output int                                  o_checked,
    output int                                  o_clamped
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DATA_W = rk3pp_pkg::DATA_W;
    localparam int FT_W   = rk3pp_pkg::FT_W;
    localparam int SC_W   = rk3pp_pkg::SC_W;

    localparam longint POP_MAX = 64'sd2147483647;
    localparam longint POP_MIN = -64'sd2147483648;
    localparam longint POP_ONE = 64'sd1 << rk3pp_pkg::FRAC_BITS;

    typedef struct {
        logic signed [DATA_W-1:0] prey;
        logic signed [DATA_W-1:0] predator;
        logic                     sat;
    } t_pop_result;

    t_pop_result         pop_expected[$];
    logic [FT_W-1:0]     end_time;
    logic [SC_W-1:0]     n_steps;
    bit                  clamp_hit;

    function automatic longint clamp32(input longint v);
        if (v > POP_MAX) begin
            clamp_hit = 1'b1;
            return POP_MAX;
        end
        if (v < POP_MIN) begin
            clamp_hit = 1'b1;
            return POP_MIN;
        end
        return v;
    endfunction

    function automatic longint round_shr(input longint v, input int s);
        return (v + (64'sd1 << (s - 1))) >>> s;
    endfunction

    function automatic longint qmul(input longint a, input longint b);
        return clamp32(round_shr(a * b, rk3pp_pkg::FRAC_BITS));
    endfunction

    function automatic longint sixth(input longint v);
        longint m;
        longint q;
        m = (v < 0) ? -v : v;
        q = (m + 3) / 6;
        return (v < 0) ? -q : q;
    endfunction

    function automatic t_pop_result integrate(input longint prey0, input longint pred0);
        t_pop_result r;
        longint h, x, y, k1a, k1b, k2a, k2b, k3a, k3b;
        longint t1a, t1b, t2a, t2b, t3a, t3b, ya, yb;
        clamp_hit = 1'b0;
        x = prey0;
        y = pred0;
        h = (n_steps != 0) ? longint'(end_time / n_steps) : 0;
        for (int s = 0; s < n_steps; s++) begin
            k1a = qmul(clamp32(POP_ONE - y), x);
            k1b = qmul(clamp32(x - POP_ONE), y);
            t1a = qmul(h, k1a);
            t1b = qmul(h, k1b);
            ya  = clamp32(x + t1a);
            yb  = clamp32(y + t1b);
            k2a = qmul(clamp32(POP_ONE - yb), ya);
            k2b = qmul(clamp32(ya - POP_ONE), yb);
            t2a = qmul(h, k2a);
            t2b = qmul(h, k2b);
            ya  = clamp32(x + round_shr(t1a + t2a, 2));
            yb  = clamp32(y + round_shr(t1b + t2b, 2));
            k3a = qmul(clamp32(POP_ONE - yb), ya);
            k3b = qmul(clamp32(ya - POP_ONE), yb);
            t3a = qmul(h, k3a);
            t3b = qmul(h, k3b);
            x   = clamp32(x + sixth(t1a + t2a + 4 * t3a));
            y   = clamp32(y + sixth(t1b + t2b + 4 * t3b));
        end
        r.prey     = x[DATA_W-1:0];
        r.predator = y[DATA_W-1:0];
        r.sat      = clamp_hit;
        return r;
    endfunction

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
        o_clamped    = 0;
        end_time     = rk3pp_pkg::FT_RESET;
        n_steps      = rk3pp_pkg::SC_RESET;
    end

    always @(posedge i_clk) begin
        t_pop_result e;
        if (!i_rst_n) begin
            end_time = rk3pp_pkg::FT_RESET;
            n_steps  = rk3pp_pkg::SC_RESET;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (pop_expected.size() == 0) begin
                    $display("%0t: unexpected result prey=%h predator=%h sat=%b", $time,
                             i_prey_final, i_predator_final, i_saturated);
                    o_fail_count++;
                end else begin
                    e = pop_expected.pop_front();
                    o_checked++;
                    if (e.sat) o_clamped++;
                    if (i_prey_final !== e.prey) begin
                        $display("%0t: prey_final expected %h actual %h", $time,
                                 e.prey, i_prey_final);
                        o_fail_count++;
                    end
                    if (i_predator_final !== e.predator) begin
                        $display("%0t: predator_final expected %h actual %h", $time,
                                 e.predator, i_predator_final);
                        o_fail_count++;
                    end
                    if (i_saturated !== e.sat) begin
                        $display("%0t: saturated expected %b actual %b", $time,
                                 e.sat, i_saturated);
                        o_fail_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                pop_expected.push_back(integrate(longint'(i_prey_start),
                                                 longint'(i_predator_start)));
            if (i_cfg_we) begin
                if (i_cfg_index == rk3pp_pkg::CFG_FINAL_TIME)
                    end_time = i_cfg_data;
                else
                    n_steps = i_cfg_data[SC_W-1:0];
            end
        end
        o_pending = pop_expected.size();
    end

endmodule

`default_nettype wire

FILE: sim/rk3_predator_prey_integrator_tb.sv
`default_nettype none

module rk3_predator_prey_integrator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DATA_W = rk3pp_pkg::DATA_W;
    localparam int FT_W   = rk3pp_pkg::FT_W;
    localparam int SC_W   = rk3pp_pkg::SC_W;

    localparam int CYCLE_LIMIT = 3000000;
    localparam logic signed [DATA_W-1:0] POP_HI = rk3pp_pkg::Q_MAX;
    localparam logic signed [DATA_W-1:0] POP_LO = rk3pp_pkg::Q_MIN;
    localparam logic signed [DATA_W-1:0] Q_ONE  = rk3pp_pkg::Q_ONE;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_in_valid;
    logic                     o_in_ready;
    logic signed [DATA_W-1:0] i_prey_start;
    logic signed [DATA_W-1:0] i_predator_start;
    logic                     o_out_valid;
    logic                     i_out_ready;
    logic signed [DATA_W-1:0] o_prey_final;
    logic signed [DATA_W-1:0] o_predator_final;
    logic                     o_saturated;
    logic                     i_cfg_we;
    logic                     i_cfg_index;
    logic [FT_W-1:0]          i_cfg_data;

    int fail_count, pending, checked, clamped;
    int cycles, sent, cfg_writes;
    bit quiet, hold_request;

    rk3_predator_prey_integrator dut (.*);

    rk3_predator_prey_checker checker_i (
        .i_clk, .i_rst_n, .i_in_valid,
        .i_in_ready      (o_in_ready),
        .i_prey_start, .i_predator_start,
        .i_out_valid     (o_out_valid),
        .i_out_ready,
        .i_prey_final    (o_prey_final),
        .i_predator_final(o_predator_final),
        .i_saturated     (o_saturated),
        .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_checked       (checked),
        .o_clamped       (clamped)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("rk3_predator_prey_integrator_tb: FAIL");
            $finish;
        end
    end

    // receiver: random backpressure, plus one long hold on request
    initial begin
        i_out_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                i_out_ready = 1'b0;
                repeat (3000) @(negedge i_clk);
                hold_request = 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                i_out_ready = 1'b0;
                repeat ($urandom_range(1, 14)) @(negedge i_clk);
            end else begin
                i_out_ready = 1'b1;
            end
        end
    end

    task automatic send_request(input logic signed [DATA_W-1:0] prey,
                                input logic signed [DATA_W-1:0] predator);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge i_clk);
        end
        i_in_valid       = 1'b1;
        i_prey_start     = prey;
        i_predator_start = predator;
        do @(posedge i_clk); while (!o_in_ready);
        sent++;
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_in_valid = 1'b0;
        while (pending != 0 || hold_request) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic write_cfg(input logic idx, input logic [FT_W-1:0] value);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        cfg_writes++;
    endtask

    task automatic set_run(input logic [FT_W-1:0] ft, input logic [SC_W-1:0] sc);
        drain();
        write_cfg(rk3pp_pkg::CFG_FINAL_TIME, ft);
        write_cfg(rk3pp_pkg::CFG_STEP_COUNT, FT_W'(sc));
    endtask

    function automatic logic signed [DATA_W-1:0] rand_pop();
        case ($urandom_range(0, 9))
            0, 1:    return $urandom;
            2:       return -$signed(DATA_W'($urandom_range(0, 32'h0004_0000)));
            default: return $urandom_range(32'h0000_2000, 32'h0004_0000);
        endcase
    endfunction

    initial begin
        i_rst_n          = 1'b0;
        i_in_valid       = 1'b0;
        i_prey_start     = '0;
        i_predator_start = '0;
        i_cfg_we         = 1'b0;
        i_cfg_index      = rk3pp_pkg::CFG_FINAL_TIME;
        i_cfg_data       = '0;
        quiet            = 1'b0;
        hold_request     = 1'b0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // reset settings: 1.0 over 1024 steps
        send_request(Q_ONE, Q_ONE / 2);

        // zero step count passes the start values through
        set_run(rk3pp_pkg::FT_RESET, '0);
        send_request(POP_HI, POP_LO);
        send_request('0, '0);
        send_request(POP_LO, POP_HI);

        // zero final time: populations held, slope clamps still flagged
        set_run('0, SC_W'(3));
        send_request(POP_HI, POP_LO);
        send_request(POP_LO, POP_LO);
        send_request(Q_ONE, Q_ONE);

        // longest end time in one step
        set_run({FT_W{1'b1}}, SC_W'(1));
        send_request(POP_HI, POP_HI);
        send_request(Q_ONE * 3, Q_ONE / 4);
        send_request(32'sh0000_0001, -32'sh0000_0001);

        set_run(FT_W'(Q_ONE), SC_W'(4));
        send_request(Q_ONE, Q_ONE);
        send_request('0, '0);
        send_request(-Q_ONE, Q_ONE * 2);
        send_request(POP_HI, POP_HI);
        send_request(POP_LO, POP_HI);
        send_request(32'shFFFF_FFFF, 32'sh7FFF_0000);

        set_run(FT_W'(1), SC_W'(2));
        send_request(Q_ONE * 2, Q_ONE / 2);

        // long output hold while requests keep coming
        set_run(FT_W'(Q_ONE / 4), SC_W'(1));
        hold_request = 1'b1;
        repeat (12) send_request(rand_pop(), rand_pop());

        for (int phase = 0; phase < 6; phase++) begin
            set_run(FT_W'($urandom_range(32'h0000_2000, 32'h0004_0000)),
                    SC_W'($urandom_range(1, 8)));
            if (phase == 5) quiet = 1'b1;
            repeat (12) send_request(rand_pop(), rand_pop());
        end

        drain();
        repeat (200) @(negedge i_clk);
        $display("covered %0d requests, %0d results checked (%0d saturated), %0d cfg writes",
                 sent, checked, clamped, cfg_writes);
        $display("step counts 0..1024, final time 0 to max, long output hold included");
        if (fail_count == 0) begin
            $display("rk3_predator_prey_integrator_tb: PASS");
        end else begin
            $display("rk3_predator_prey_integrator_tb: FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: sim.f
src/rk3pp_pkg.sv
src/rk3pp_div.sv
src/rk3pp_ctrl.sv
src/rk3pp_dp.sv
src/rk3_predator_prey_integrator.sv
sim/rk3_predator_prey_checker.sv
sim/rk3_predator_prey_integrator_tb.sv
